[sv/binary_gcd_lcm_assert.svh]
// Assertion macros used by the checker file of binary_gcd_lcm.
// Depends on nothing; the including scope provides aclk and aresetn.
`ifndef BINARY_GCD_LCM_ASSERT_SVH
`define BINARY_GCD_LCM_ASSERT_SVH

// check while out of reset
`define BGL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on every edge, reset included
`define BGL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/bgl_pkg.sv]
// Package for binary_gcd_lcm: field widths, default operand width, sequencer states.
// Depends on nothing.
package bgl_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int IN_W              = 32;
    localparam int DIV_W             = 32;
    localparam int MUL_W             = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } bgl_state_t;

endpackage

[sv/bgl_gcd.sv]
// Iterative binary (Stein) greatest common divisor, one reduction step per cycle.
// Depends on bgl_pkg for the default operand width.
module bgl_gcd #(
    parameter int OPERAND_WIDTH = bgl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] a_in,
    input  logic [OPERAND_WIDTH-1:0] b_in,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] gcd
);

    localparam int W  = OPERAND_WIDTH;
    localparam int TW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [TW-1:0] twos_reg, twos_next;
    logic [W-1:0]  g_reg, g_next;

    logic          a_eq_b, any_zero, any_one, term, a_gt_b;
    logic [W-1:0]  base, diff;

    always_comb begin
        a_eq_b   = (a_reg == b_reg);
        any_zero = (a_reg == '0) || (b_reg == '0);
        any_one  = (a_reg == W'(1)) || (b_reg == W'(1));
        term     = a_eq_b || any_zero || any_one;
        a_gt_b   = (a_reg > b_reg);
        diff     = a_gt_b ? (a_reg - b_reg) : (b_reg - a_reg);

        priority if (a_eq_b) begin
            base = a_reg;
        end else if (any_zero) begin
            base = a_reg | b_reg;
        end else begin
            base = W'(1);
        end

        a_next    = a_reg;
        b_next    = b_reg;
        twos_next = twos_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        g_next    = g_reg;

        if (start) begin
            a_next    = a_in;
            b_next    = b_in;
            twos_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg && term) begin
            busy_next = 1'b0;
            done_next = 1'b1;
            g_next    = base << twos_reg;
        end else if (busy_reg) begin
            unique case ({a_reg[0], b_reg[0]})
                2'b11: begin
                    if (a_gt_b) begin
                        a_next = diff >> 1;
                    end else begin
                        b_next = diff >> 1;
                    end
                end
                2'b10: b_next = b_reg >> 1;
                2'b01: a_next = a_reg >> 1;
                default: begin
                    a_next    = a_reg >> 1;
                    b_next    = b_reg >> 1;
                    twos_next = twos_reg + TW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        twos_reg <= twos_next;
        g_reg    <= g_next;
    end

    assign done = done_reg;
    assign gcd  = g_reg;

endmodule

[sv/bgl_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on bgl_pkg for the default operand width.
module bgl_div #(
    parameter int OPERAND_WIDTH = bgl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] dividend,
    input  logic [OPERAND_WIDTH-1:0] divisor,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] quotient
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;

    logic [W:0]    trial, sub;
    logic          fits;

    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        sub   = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? sub[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/bgl_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle, full-width product.
// Depends on bgl_pkg for the default operand width.
module bgl_mul #(
    parameter int OPERAND_WIDTH = bgl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [OPERAND_WIDTH-1:0]   x_in,
    input  logic [OPERAND_WIDTH-1:0]   y_in,
    output logic                       done,
    output logic [2*OPERAND_WIDTH-1:0] product
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   mcand_reg, mcand_next;
    logic [2*W-1:0] prod_reg, prod_next;

    logic [W-1:0]   addend;
    logic [W:0]     sum;

    always_comb begin
        addend = prod_reg[0] ? mcand_reg : '0;
        sum    = {1'b0, prod_reg[2*W-1:W]} + {1'b0, addend};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;

        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CW'(W - 1);
            mcand_next = x_in;
            prod_next  = {{W{1'b0}}, y_in};
        end else if (busy_reg) begin
            prod_next = {sum, prod_reg[W-1:1]};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg   <= cnt_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

[sv/binary_gcd_lcm.sv]
// binary_gcd_lcm top: GCD by Stein's method, then LCM as (a / gcd) * b; uses bgl_pkg.
// Binary GCD loop first, then divider and multiplier (both skipped on a zero operand).
// One item at a time: a new input is accepted only after the result has been taken.
// Reset (synchronous, active low) drops any item in flight; the block is ready next cycle.
module binary_gcd_lcm #(
    parameter int OPERAND_WIDTH = bgl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [bgl_pkg::IN_W-1:0]  s_first_operand,
    input  logic [bgl_pkg::IN_W-1:0]  s_second_operand,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bgl_pkg::DIV_W-1:0] m_common_divisor,
    output logic [bgl_pkg::MUL_W-1:0] m_common_multiple
);

    import bgl_pkg::*;

    localparam int W = OPERAND_WIDTH;

    bgl_state_t     state_reg, state_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   cd_reg, cd_next;
    logic [2*W-1:0] cm_reg, cm_next;

    logic           gcd_kick_reg;
    logic           div_kick_reg;
    logic           gcd_done;
    logic           div_done;
    logic           mul_start, mul_done;
    logic [W-1:0]   gcd_val, quo_val;
    logic [2*W-1:0] prod_val;

    bgl_gcd #(.OPERAND_WIDTH(W)) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_kick_reg),
        .a_in    (a_reg),
        .b_in    (b_reg),
        .done    (gcd_done),
        .gcd     (gcd_val)
    );

    bgl_div #(.OPERAND_WIDTH(W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_kick_reg),
        .dividend (a_reg),
        .divisor  (cd_reg),
        .done     (div_done),
        .quotient (quo_val)
    );

    bgl_mul #(.OPERAND_WIDTH(W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x_in    (quo_val),
        .y_in    (b_reg),
        .done    (mul_done),
        .product (prod_val)
    );

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cd_next    = cd_reg;
        cm_next    = cm_reg;
        mul_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next     = s_first_operand[W-1:0];
                    b_next     = s_second_operand[W-1:0];
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (gcd_done) begin
                    cd_next = gcd_val;
                    if ((a_reg == '0) || (b_reg == '0)) begin
                        cm_next    = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    cm_next    = prod_val;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // kick the GCD unit the cycle after the transfer, once operands are registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gcd_kick_reg <= 1'b0;
            div_kick_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gcd_kick_reg <= (state_reg == ST_IDLE) && s_valid;
            div_kick_reg <= (state_reg == ST_GCD) && gcd_done
                            && (a_reg != '0) && (b_reg != '0);
        end
        a_reg  <= a_next;
        b_reg  <= b_next;
        cd_reg <= cd_next;
        cm_reg <= cm_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = (state_reg == ST_OUT);
    assign m_common_divisor  = DIV_W'(cd_reg);
    assign m_common_multiple = MUL_W'(cm_reg);

endmodule

[sv/bgl_checker.sv]
// Port-level checker for binary_gcd_lcm and the bind that attaches it.
// Depends on bgl_pkg for port widths and on binary_gcd_lcm_assert.svh for the macros.
`include "binary_gcd_lcm_assert.svh"

module bgl_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [bgl_pkg::IN_W-1:0]  s_first_operand,
    input logic [bgl_pkg::IN_W-1:0]  s_second_operand,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [bgl_pkg::DIV_W-1:0] m_common_divisor,
    input logic [bgl_pkg::MUL_W-1:0] m_common_multiple
);

    `BGL_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (s_ready && !m_valid), "reset must leave block idle")
    `BGL_ASSERT(a_one_at_a_time, m_valid |-> !s_ready, "input taken while result pending")
    `BGL_ASSERT(a_no_instant_result, (s_valid && s_ready) |=> (!m_valid && !s_ready), "transfer in must start work")
    `BGL_ASSERT(a_ready_after_out, (m_valid && m_ready) |=> (s_ready && !m_valid), "result transfer must free block")
    `BGL_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_common_divisor) && $stable(m_common_multiple)), "stalled result changed")

endmodule

bind binary_gcd_lcm bgl_checker u_bgl_checker (.*);
